/* rtl/fifo_queue_with_delete_by_value_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO queue with delete by value
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_BY_VALUE_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_BY_VALUE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FQD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fqd_pkg.sv */
// ----------------------------------------------------------------------------
// fqd_pkg
// Types and codes shared by the FIFO queue with delete by value.
// ----------------------------------------------------------------------------
package fqd_pkg;

  // Default queue depth.
  localparam int DEPTH_DEF = 16;

  // Width of one stored value.
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [1:0]               action_t;
  typedef logic [1:0]               status_t;

  // Action codes.
  localparam action_t ACT_PUT = 2'd0;
  localparam action_t ACT_GET = 2'd1;
  localparam action_t ACT_DEL = 2'd2;

  // Status codes.
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

/* rtl/fqd_ram.sv */
// ----------------------------------------------------------------------------
// fqd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fifo_queue_with_delete_by_value_top.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value_top
// Bounded FIFO of signed 32-bit values with put, get and delete by value.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per command:
//   action selects put, get or delete, and data_value is the value to
//   append or the key to remove. Each command yields exactly one beat on
//   the output channel (out_valid/out_ready) with result_value and status.
//   Entries live in a circular buffer in a single RAM, so put and get are
//   short: a put goes from idle straight to S_FIN, a get via S_GET.
//   A delete walks the stored entries oldest first through the one RAM
//   read port, one entry per cycle, comparing each against the key; once
//   the match is found, every later entry is copied one slot back through
//   the write port in the same pass. A delete's length therefore grows
//   with the occupancy, set by that read port. One command is in flight
//   at a time; in_ready is high only when idle, so a new command is taken
//   only after the last one has moved its result to the output register.
//   The result sits in an output register; a stalled receiver holds it,
//   and a new command may be accepted meanwhile, but its result waits
//   until the register is taken. Reset empties the queue at once.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_delete_by_value_top_macros.svh"

module fifo_queue_with_delete_by_value_top #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqd_pkg::action_t  action,
  input  fqd_pkg::data_t    data_value,
  output logic              out_valid,
  input  logic              out_ready,
  output fqd_pkg::data_t    result_value,
  output fqd_pkg::status_t  status
);

  import fqd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef logic [PW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  localparam ptr_t LAST_PTR = ptr_t'(DEPTH - 1);
  localparam cnt_t FULL_CNT = cnt_t'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_DEL,
    S_FIN
  } state_t;

  // Circular pointer steps.
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  state_t  state;
  ptr_t    head;
  ptr_t    tail;
  cnt_t    occ;
  ptr_t    rd_ptr;
  ptr_t    pend_ptr;
  ptr_t    prev_ptr;
  cnt_t    rd_k;
  logic    pend;
  logic    found;
  data_t   key;
  data_t   res_value;
  status_t res_status;

  logic    accept;
  logic    put_ok;
  logic    match;
  logic    ram_we;
  ptr_t    ram_waddr;
  data_t   ram_wdata;
  ptr_t    ram_raddr;
  data_t   ram_rdata;

  // Handshake and RAM port steering.
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign put_ok    = accept && (action == ACT_PUT) && (occ != FULL_CNT);
  assign ram_we    = put_ok || ((state == S_DEL) && pend && found);
  assign ram_waddr = put_ok ? tail : prev_ptr;
  assign ram_wdata = put_ok ? data_value : ram_rdata;
  assign ram_raddr = (state == S_DEL) ? rd_ptr : head;
  assign match     = (ram_rdata == key);

  fqd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, queue pointers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      rd_k      <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A taken beat empties the output register unless a new one loads now.
      if (out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= data_value;
            res_value  <= '0;
            res_status <= ST_MISS;
            unique case (action)
              ACT_PUT: begin
                if (occ == FULL_CNT) begin
                  res_status <= ST_FULL;
                end else begin
                  tail       <= ptr_inc(tail);
                  occ        <= occ + 1'b1;
                  res_status <= ST_OK;
                end
                state <= S_FIN;
              end
              ACT_GET: begin
                state <= (occ == '0) ? S_FIN : S_GET;
              end
              ACT_DEL: begin
                rd_ptr <= head;
                rd_k   <= '0;
                pend   <= 1'b0;
                found  <= 1'b0;
                state  <= S_DEL;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_GET: begin
          // The oldest entry arrives from the RAM in the cycle after the read.
          res_value  <= ram_rdata;
          res_status <= ST_OK;
          head       <= ptr_inc(head);
          occ        <= occ - 1'b1;
          state      <= S_FIN;
        end
        S_DEL: begin
          // Issue one read per cycle until every stored entry is fetched.
          if (rd_k != occ) begin
            rd_ptr   <= ptr_inc(rd_ptr);
            rd_k     <= rd_k + 1'b1;
            pend_ptr <= rd_ptr;
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          // Compare returning data; after a match, entries move back a slot.
          if (pend) begin
            prev_ptr <= pend_ptr;
            if (!found && match) begin
              found     <= 1'b1;
              res_value <= ram_rdata;
            end
          end
          // The pass ends once the last fetched entry has been handled.
          if ((rd_k == occ) && !pend) begin
            if (found) begin
              occ        <= occ - 1'b1;
              tail       <= ptr_dec(tail);
              res_status <= ST_OK;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_value <= res_value;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  // The fill count never passes the queue depth.
  `FQD_ASSERT_IMP(a_occ_bound, 1'b1, occ <= FULL_CNT, "occupancy above depth")

  // An accepted put on a non-full queue grows it by exactly one.
  `FQD_ASSERT_NEXT(a_put_grows, put_ok,
                   occ == cnt_t'($past(occ) + 1'b1), "put did not grow queue")

  // A delete that has matched holds the key as its result value.
  `FQD_ASSERT_IMP(a_del_value, (state == S_DEL) && found, res_value == key,
                  "delete value mismatch")

  // A full status is only reported while the queue is full.
  `FQD_ASSERT_IMP(a_full_status, (state == S_FIN) && (res_status == ST_FULL),
                  occ == FULL_CNT, "full status on non-full queue")

endmodule
